>>> design/double_tap_wake_detector_top_assert.svh
// ----------------------------------------------------------------------------
// double tap wake detector assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_TAP_WAKE_DETECTOR_TOP_ASSERT_SVH
`define DOUBLE_TAP_WAKE_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle
`define DTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// consequent must hold in the next cycle
`define DTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DTW_ASSERT_SAME(lbl, ante, cons, msg)
`define DTW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/dtw_pkg.sv
// ----------------------------------------------------------------------------
// dtw_pkg
// Widths, event codes, register indexes and reset values of the detector.
// ----------------------------------------------------------------------------
package dtw_pkg;

  // geometry and timer widths
  localparam int COORD_BITS = 13;
  localparam int TIME_BITS  = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TIME_BITS-1:0]  elapsed_t;

  localparam logic [31:0] COORD_MAX_W = 32'((64'd1 << COORD_BITS) - 64'd1);

  // event codes
  localparam logic [9:0] CODE_SLOT      = 10'd47;
  localparam logic [9:0] CODE_TRACK     = 10'd57;
  localparam logic [9:0] CODE_POS_X     = 10'd53;
  localparam logic [9:0] CODE_POS_Y     = 10'd54;
  localparam logic [9:0] CODE_TOUCH_KEY = 10'd330;

  // region filter limits and vibrate ceiling
  localparam coord_t     REGION_LOW  = COORD_BITS'(1280);
  localparam coord_t     REGION_HIGH = COORD_BITS'(1920);
  localparam logic [6:0] VIB_MAX     = 7'd90;

  // region select codes
  localparam logic [1:0] REGION_NOT_LOW = 2'd1;
  localparam logic [1:0] REGION_BELOW_HIGH = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_SCREEN_OFF   = 3'd1;
  localparam logic [2:0] REG_PHONE_CALL   = 3'd2;
  localparam logic [2:0] REG_REGION_SEL   = 3'd3;
  localparam logic [2:0] REG_DCLICK_EN    = 3'd4;
  localparam logic [2:0] REG_TAP_RADIUS   = 3'd5;
  localparam logic [2:0] REG_TAP_WINDOW   = 3'd6;
  localparam logic [2:0] REG_VIBRATE      = 3'd7;

  // configuration reset values
  localparam logic [12:0] TAP_RADIUS_RST = 13'd50;
  localparam logic [15:0] TAP_WINDOW_RST = 16'd600;
  localparam logic [6:0]  VIBRATE_RST    = 7'd50;

  // tap counter values
  localparam logic [1:0] TAPS_NONE  = 2'd0;
  localparam logic [1:0] TAPS_ONE   = 2'd1;
  localparam logic [1:0] TAPS_TWO   = 2'd2;

endpackage

>>> design/double_tap_wake_detector_top.sv
// ----------------------------------------------------------------------------
// double_tap_wake_detector_top
// Double tap to wake gesture detector on a touch event and tick stream.
// ----------------------------------------------------------------------------
//  channel  ports                                   direction
//  in       in_valid/in_ready, mode, code, value    event or tick beat in
//  out      out_valid/out_ready, wake, level, taps  one result beat per input
//  cfg      cfg_we, cfg_index, cfg_wdata            register write, no wait
//
//  One beat per cycle: every beat is worked by a single level of compares
//  and adders straight into the detector state and the result register.
//  A beat is taken whenever the result register is empty or being drained.
//  A stalled result holds while out_ready is low, and input stalls with it.
//  Synchronous active low reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "double_tap_wake_detector_top_assert.svh"

module double_tap_wake_detector_top
  import dtw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [9:0]         in_event_code,
  input  logic signed [31:0] in_event_value,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_wake_pulse,
  output logic [6:0]         out_vibrate_level,
  output logic [1:0]         out_taps_seen,
  // configuration writes
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  // configuration registers
  logic        enable_r;
  logic        screen_off_r;
  logic        phone_call_r;
  logic [1:0]  region_sel_r;
  logic        dclick_en_r;
  logic [12:0] tap_radius_r;
  logic [15:0] tap_window_r;
  logic [6:0]  vibrate_r;

  // detector state
  logic [1:0]  tap_count_r, tap_count_nxt;
  coord_t      first_x_r, first_x_nxt;
  coord_t      first_y_r, first_y_nxt;
  elapsed_t    elapsed_r, elapsed_nxt;
  logic        armed_r, armed_nxt;
  coord_t      latest_x_r, latest_x_nxt;
  coord_t      latest_y_r, latest_y_nxt;

  // result register
  logic        out_valid_r;
  logic        out_wake_r, out_wake_nxt;
  logic [6:0]  out_level_r;
  logic [1:0]  out_taps_r;

  logic        in_fire;
  logic        ev_active;
  coord_t      coord_sat;
  logic        region_pass;
  coord_t      dx, dy;
  logic        tap_match;
  logic [6:0]  level_cap;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      screen_off_r <= 1'b0;
      phone_call_r <= 1'b0;
      region_sel_r <= 2'd0;
      dclick_en_r  <= 1'b1;
      tap_radius_r <= TAP_RADIUS_RST;
      tap_window_r <= TAP_WINDOW_RST;
      vibrate_r    <= VIBRATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:     enable_r     <= cfg_wdata[0];
        REG_SCREEN_OFF: screen_off_r <= cfg_wdata[0];
        REG_PHONE_CALL: phone_call_r <= cfg_wdata[0];
        REG_REGION_SEL: region_sel_r <= cfg_wdata[1:0];
        REG_DCLICK_EN:  dclick_en_r  <= cfg_wdata[0];
        REG_TAP_RADIUS: tap_radius_r <= cfg_wdata[12:0];
        REG_TAP_WINDOW: tap_window_r <= cfg_wdata;
        REG_VIBRATE:    vibrate_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // coordinate saturation: negative to zero, large to the top of range
  always_comb begin
    if (in_event_value[31]) begin
      coord_sat = '0;
    end else if ($unsigned(in_event_value) > COORD_MAX_W) begin
      coord_sat = '1;
    end else begin
      coord_sat = in_event_value[COORD_BITS-1:0];
    end
  end

  // latest point after this beat
  assign ev_active = !in_mode && !phone_call_r && screen_off_r;

  always_comb begin
    latest_x_nxt = latest_x_r;
    latest_y_nxt = latest_y_r;
    if (ev_active && in_event_code == CODE_POS_X) begin
      latest_x_nxt = coord_sat;
    end
    if (ev_active && in_event_code == CODE_POS_Y) begin
      latest_y_nxt = coord_sat;
    end
  end

  // region filter on the updated y
  always_comb begin
    case (region_sel_r)
      REGION_NOT_LOW:    region_pass = (latest_y_nxt != REGION_LOW);
      REGION_BELOW_HIGH: region_pass = (latest_y_nxt < REGION_HIGH);
      default:           region_pass = (latest_y_nxt < REGION_LOW);
    endcase
  end

  // distance and window check of the second tap
  assign dx = (latest_x_nxt > first_x_r) ? latest_x_nxt - first_x_r
                                         : first_x_r - latest_x_nxt;
  assign dy = (latest_y_nxt > first_y_r) ? latest_y_nxt - first_y_r
                                         : first_y_r - latest_y_nxt;
  assign tap_match = (32'(dx) < 32'(tap_radius_r)) &&
                     (32'(dy) < 32'(tap_radius_r)) &&
                     (32'(elapsed_r) < 32'(tap_window_r));

  // detector next state
  always_comb begin
    tap_count_nxt = tap_count_r;
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    elapsed_nxt   = elapsed_r;
    armed_nxt     = armed_r;
    out_wake_nxt  = 1'b0;
    if (in_mode) begin
      if (elapsed_r != '1) begin
        elapsed_nxt = elapsed_r + 1'b1;
      end
    end else if (ev_active) begin
      if (in_event_code == CODE_SLOT) begin
        tap_count_nxt = TAPS_NONE;
        first_x_nxt   = '0;
        first_y_nxt   = '0;
        elapsed_nxt   = '0;
      end else if ((in_event_code == CODE_TRACK && in_event_value == -32'sd1) ||
                   (in_event_code == CODE_TOUCH_KEY && in_event_value == 32'sd0)) begin
        armed_nxt = 1'b1;
      end else if ((in_event_code == CODE_POS_X || in_event_code == CODE_POS_Y) &&
                   region_pass && enable_r && armed_r) begin
        armed_nxt = 1'b0;
        if (tap_count_r == TAPS_ONE && tap_match) begin
          // second tap qualifies
          if (dclick_en_r) begin
            tap_count_nxt = TAPS_NONE;
            first_x_nxt   = '0;
            first_y_nxt   = '0;
            elapsed_nxt   = '0;
            out_wake_nxt  = 1'b1;
          end else begin
            tap_count_nxt = TAPS_TWO;
          end
        end else begin
          // start over with this point as the first tap
          tap_count_nxt = TAPS_ONE;
          first_x_nxt   = latest_x_nxt;
          first_y_nxt   = latest_y_nxt;
          elapsed_nxt   = '0;
        end
      end
    end
  end

  assign level_cap = (vibrate_r > VIB_MAX) ? VIB_MAX : vibrate_r;

  // detector state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPS_NONE;
      first_x_r   <= '0;
      first_y_r   <= '0;
      elapsed_r   <= '0;
      armed_r     <= 1'b1;
      latest_x_r  <= '0;
      latest_y_r  <= '0;
    end else if (in_fire) begin
      tap_count_r <= tap_count_nxt;
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      elapsed_r   <= elapsed_nxt;
      armed_r     <= armed_nxt;
      latest_x_r  <= latest_x_nxt;
      latest_y_r  <= latest_y_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_wake_r  <= out_wake_nxt;
      out_level_r <= out_wake_nxt ? level_cap : 7'd0;
      out_taps_r  <= tap_count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wake_pulse    = out_wake_r;
  assign out_vibrate_level = out_level_r;
  assign out_taps_seen     = out_taps_r;

  // checks
  `DTW_ASSERT_SAME(a_level_only_on_wake, out_valid_r && !out_wake_r,
                   out_level_r == 7'd0, "vibrate level without wake")
  `DTW_ASSERT_SAME(a_wake_clears_taps, out_valid_r && out_wake_r,
                   out_taps_r == TAPS_NONE, "wake left taps counted")
  `DTW_ASSERT_SAME(a_tap_count_range, 1'b1,
                   tap_count_r != 2'd3, "tap count out of range")
  `DTW_ASSERT_NEXT(a_tick_keeps_arm, in_fire && in_mode,
                   $stable(armed_r) && $stable(tap_count_r), "tick changed tap state")

endmodule
